FILE: rtl/lrt_pkg.sv
// constants, types and helpers shared by the recurrence term block
package lrt_pkg;

    localparam int unsigned VALUE_W   = 30;
    localparam int unsigned DIM       = 6;
    localparam int unsigned REGION_SZ = 36;
    localparam int unsigned REGIONS   = 4;
    localparam int unsigned RAM_DEPTH = REGION_SZ * REGIONS;
    localparam int unsigned ADDR_W    = 8;
    localparam int unsigned IDX_BITS_DEF = 32;
    localparam int unsigned TERM_W    = 32;

    localparam logic [63:0] PRIME64  = 64'd1000000007;
    localparam logic [29:0] PRIME    = PRIME64[29:0];
    localparam logic [30:0] PRIME_X2 = 31'(PRIME64 * 64'd2);
    localparam logic [63:0] MU64     = (64'd1 << 60) / PRIME64;
    localparam logic [30:0] MU       = MU64[30:0];

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INIT,
        ST_CHECK,
        ST_MUL_ISSUE,
        ST_MUL_DRAIN,
        ST_FIN_ISSUE,
        ST_FIN_DRAIN
    } t_state;

    typedef enum logic {
        OP_ACC,
        OP_SQR
    } t_op;

    typedef struct packed {
        logic              valid;
        logic              first;
        logic              last;
        logic              fin;
        logic [2:0]        k;
        logic [ADDR_W-1:0] waddr;
    } t_ctl;

    function automatic logic [ADDR_W-1:0] elem_addr(input logic [1:0] region,
                                                    input logic [2:0] row,
                                                    input logic [2:0] col);
        logic [ADDR_W-1:0] a;
        a = ADDR_W'(region) * ADDR_W'(REGION_SZ) + ADDR_W'(row) * ADDR_W'(DIM)
            + ADDR_W'(col);
        return a;
    endfunction

endpackage

FILE: rtl/linear_recurrence_term_mod_prime.sv
// die-roll sequence count mod prime by companion matrix power on one modular mac pipe
// sequence: matrix load, then per exponent bit a check followed by one 6x6 product
// (216 pipelined multiply-accumulates, then a pipe drain) for a clear bit and two for a
// set bit, then the seed product to the strobe; busy stays high throughout, and only one
// request is taken at a time
// result strobed for one cycle; synchronous active-low reset returns the sequencer to idle
module linear_recurrence_term_mod_prime #(
    parameter int unsigned INDEX_BITS = lrt_pkg::IDX_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [lrt_pkg::TERM_W-1:0]   i_term_index,
    output logic                         o_done,
    output logic [lrt_pkg::VALUE_W-1:0]  o_term_value
);
    import lrt_pkg::*;

    t_state r_state, n_state;
    t_op    r_op, n_op;
    logic [INDEX_BITS-1:0] r_exp, n_exp;
    logic [1:0] r_acc_rg, n_acc_rg, r_base_rg, n_base_rg, dest_rg;
    logic [2:0] r_i, n_i, r_j, n_j, r_k, n_k;
    logic       r_ir, n_ir;
    t_ctl       issue_ctl, r_c1, r_c2, r_c3, r_c4, r_c5;
    logic [ADDR_W-1:0] raddr_a, raddr_b, waddr;
    logic       we;
    logic [VALUE_W-1:0] wdata, rd_a, rd_b, op_b;
    logic [59:0] r_prod;
    logic [61:0] r_qh;
    logic [31:0] r_plo2, r_plo3, r_qp;
    logic [60:0] qp_full;
    logic [31:0] diff;
    logic [VALUE_W-1:0] r_r, n_r, r_accum, sum_red;
    logic [30:0] sum;
    logic [63:0] idx_ext;
    logic [INDEX_BITS-1:0] n_val;
    logic pipe_busy;

    assign idx_ext = {32'd0, i_term_index};
    assign n_val   = idx_ext[INDEX_BITS-1:0];
    assign busy    = (r_state != ST_IDLE);
    assign pipe_busy = r_c1.valid | r_c2.valid | r_c3.valid | r_c4.valid | r_c5.valid;

    always_comb begin
        dest_rg = 2'd3;
        for (int g = 2; g >= 0; g--) begin
            if (2'(g) != r_acc_rg && 2'(g) != r_base_rg) begin
                dest_rg = 2'(g);
            end
        end
    end

    lrt_ram #(.WIDTH(VALUE_W), .DEPTH(RAM_DEPTH)) u_ram (
        .i_clk     (i_clk),
        .i_we      (we),
        .i_waddr   (waddr),
        .i_wdata   (wdata),
        .i_raddr_a (raddr_a),
        .i_raddr_b (raddr_b),
        .o_rdata_a (rd_a),
        .o_rdata_b (rd_b)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_c1 <= '0;
            r_c2 <= '0;
            r_c3 <= '0;
            r_c4 <= '0;
            r_c5 <= '0;
            o_done <= 1'b0;
        end else begin
            r_state <= n_state;
            r_c1 <= issue_ctl;
            r_c2 <= r_c1;
            r_c3 <= r_c2;
            r_c4 <= r_c3;
            r_c5 <= r_c4;
            o_done <= r_c5.valid & r_c5.last & r_c5.fin;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op      <= n_op;
        r_exp     <= n_exp;
        r_acc_rg  <= n_acc_rg;
        r_base_rg <= n_base_rg;
        r_i <= n_i;
        r_j <= n_j;
        r_k <= n_k;
        r_ir <= n_ir;
        r_prod <= 60'(rd_a) * 60'(op_b);
        r_plo2 <= r_prod[31:0];
        r_qh   <= 62'(r_prod[59:29]) * 62'(MU);
        r_plo3 <= r_plo2;
        r_qp   <= qp_full[31:0];
        r_r    <= n_r;
        if (r_c5.valid) begin
            r_accum <= sum_red;
        end
        if (r_c5.valid & r_c5.last & r_c5.fin) begin
            o_term_value <= sum_red;
        end
    end

    // barrett reduction and accumulate
    always_comb begin
        op_b    = r_c1.fin ? (VALUE_W'(1) << r_c1.k) : rd_b;
        qp_full = 61'(r_qh[61:31]) * 61'(PRIME);
        diff    = r_plo3 - r_qp;
        if (diff >= 32'(PRIME_X2)) begin
            n_r = VALUE_W'(diff - 32'(PRIME_X2));
        end else if (diff >= 32'(PRIME)) begin
            n_r = VALUE_W'(diff - 32'(PRIME));
        end else begin
            n_r = VALUE_W'(diff);
        end
        sum = (r_c5.first ? 31'd0 : 31'(r_accum)) + 31'(r_r);
        sum_red = (sum >= 31'(PRIME)) ? VALUE_W'(sum - 31'(PRIME)) : VALUE_W'(sum);
    end

    always_comb begin
        n_state   = r_state;
        n_op      = r_op;
        n_exp     = r_exp;
        n_acc_rg  = r_acc_rg;
        n_base_rg = r_base_rg;
        n_i = r_i;
        n_j = r_j;
        n_k = r_k;
        n_ir = r_ir;
        issue_ctl = '0;
        raddr_a = elem_addr(r_op == OP_ACC ? r_acc_rg : r_base_rg, r_i, r_k);
        raddr_b = elem_addr(r_base_rg, r_k, r_j);
        we    = r_c5.valid & r_c5.last & ~r_c5.fin;
        waddr = r_c5.waddr;
        wdata = sum_red;
        unique case (r_state)
            ST_IDLE: begin
                if (start) begin
                    n_exp     = (n_val == '0) ? '0 : n_val - INDEX_BITS'(1);
                    n_acc_rg  = 2'd0;
                    n_base_rg = 2'd1;
                    n_i = 3'd0;
                    n_j = 3'd0;
                    n_ir = 1'b0;
                    n_state = ST_INIT;
                end
            end
            ST_INIT: begin
                we    = 1'b1;
                waddr = elem_addr({1'b0, r_ir}, r_i, r_j);
                if (r_ir) begin
                    wdata = VALUE_W'((r_i == 3'd5) || (r_j == r_i + 3'd1));
                end else begin
                    wdata = VALUE_W'(r_i == r_j);
                end
                n_j = (r_j == 3'd5) ? 3'd0 : r_j + 3'd1;
                if (r_j == 3'd5) begin
                    n_i = (r_i == 3'd5) ? 3'd0 : r_i + 3'd1;
                    if (r_i == 3'd5) begin
                        n_ir = 1'b1;
                        if (r_ir) begin
                            n_state = ST_CHECK;
                        end
                    end
                end
            end
            ST_CHECK: begin
                n_i = 3'd0;
                n_j = 3'd0;
                n_k = 3'd0;
                if (r_exp == '0) begin
                    n_state = ST_FIN_ISSUE;
                end else begin
                    n_op    = r_exp[0] ? OP_ACC : OP_SQR;
                    n_state = ST_MUL_ISSUE;
                end
            end
            ST_MUL_ISSUE: begin
                issue_ctl.valid = 1'b1;
                issue_ctl.first = (r_k == 3'd0);
                issue_ctl.last  = (r_k == 3'd5);
                issue_ctl.k     = r_k;
                issue_ctl.waddr = elem_addr(dest_rg, r_i, r_j);
                n_k = (r_k == 3'd5) ? 3'd0 : r_k + 3'd1;
                if (r_k == 3'd5) begin
                    n_j = (r_j == 3'd5) ? 3'd0 : r_j + 3'd1;
                    if (r_j == 3'd5) begin
                        n_i = (r_i == 3'd5) ? 3'd0 : r_i + 3'd1;
                        if (r_i == 3'd5) begin
                            n_state = ST_MUL_DRAIN;
                        end
                    end
                end
            end
            ST_MUL_DRAIN: begin
                if (!pipe_busy) begin
                    if (r_op == OP_ACC) begin
                        n_acc_rg = dest_rg;
                        n_op     = OP_SQR;
                        n_state  = ST_MUL_ISSUE;
                    end else begin
                        n_base_rg = dest_rg;
                        n_exp     = r_exp >> 1;
                        n_state   = ST_CHECK;
                    end
                end
            end
            ST_FIN_ISSUE: begin
                raddr_a = elem_addr(r_acc_rg, 3'd0, r_k);
                issue_ctl.valid = 1'b1;
                issue_ctl.first = (r_k == 3'd0);
                issue_ctl.last  = (r_k == 3'd5);
                issue_ctl.fin   = 1'b1;
                issue_ctl.k     = r_k;
                n_k = r_k + 3'd1;
                if (r_k == 3'd5) begin
                    n_k = 3'd0;
                    n_state = ST_FIN_DRAIN;
                end
            end
            ST_FIN_DRAIN: begin
                if (!pipe_busy) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end
endmodule

FILE: rtl/lrt_ram.sv
// generic ram, one write port and two registered read ports
module lrt_ram #(
    parameter int unsigned WIDTH = 30,
    parameter int unsigned DEPTH = 144
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_a,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic [WIDTH-1:0]         o_rdata_a,
    output logic [WIDTH-1:0]         o_rdata_b
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata_a <= r_mem[i_raddr_a];
        o_rdata_b <= r_mem[i_raddr_b];
    end
endmodule
